FILE: design/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// Shared types and constants of the heading-angle PID controller: fixed-point
// constants, configuration register indexes, operation codes and FSM states.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;

    // Angle constants in Q16.16, held at the width of the raw error difference.
    localparam logic signed [32:0] DEG180     = 33'sd11796480;
    localparam logic signed [32:0] DEG360     = 33'sd23592960;
    localparam logic signed [32:0] NEG_DEG180 = -33'sd11796480;

    // Magnitude bound of the derivative term.
    localparam logic [63:0] D_TERM_BOUND = 64'h2000_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_E,
        ST_INTEG,
        ST_DNUM_A,
        ST_DNUM_B,
        ST_ITERM,
        ST_DIV,
        ST_SAT
    } apc_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } apc_div_state_t;

endpackage

FILE: design/apc_divider.sv
// ----------------------------------------------------------------------------
// apc_divider
// Sequential signed 64-bit by unsigned 16-bit divider, two quotient bits per
// cycle, truncating toward zero, with the quotient magnitude clamped to the
// derivative term bound.
// ----------------------------------------------------------------------------
module apc_divider
    import apc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] numer,
    input  logic        [15:0] denom,
    output logic               done,
    output logic signed [63:0] quotient
);

    apc_div_state_t state_reg, state_next;

    logic [63:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [16:0] t1, t2;
    logic        ge1, ge2;
    logic [15:0] r1, r2;
    logic [63:0] qmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (cnt_reg == 5'd31)
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    // Two restoring steps per cycle on a 16-bit remainder.
    always_comb
    begin
        t1  = {rem_reg, quo_reg[63]};
        ge1 = (t1 >= {1'b0, den_reg});
        r1  = ge1 ? 16'(t1 - {1'b0, den_reg}) : t1[15:0];
        t2  = {r1, quo_reg[62]};
        ge2 = (t2 >= {1'b0, den_reg});
        r2  = ge2 ? 16'(t2 - {1'b0, den_reg}) : t2[15:0];
        qmag = (quo_reg > D_TERM_BOUND) ? D_TERM_BOUND : quo_reg;
    end

    // Datapath and outputs.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    neg_next = numer[63];
                    quo_next = numer[63] ? 64'(-numer) : 64'(numer);
                    rem_next = '0;
                    den_next = denom;
                    cnt_next = '0;
                end
            end
            DV_RUN:
            begin
                quo_next = {quo_reg[61:0], ge1, ge2};
                rem_next = r2;
                cnt_next = 5'(cnt_reg + 5'd1);
            end
            DV_FIX:
            begin
                quo_next  = neg_reg ? 64'(-qmag) : qmag;
                done_next = 1'b1;
            end
            default:
            begin
                quo_next = quo_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = $signed(quo_reg);

endmodule

FILE: design/angle_pid_controller_core.sv
// ----------------------------------------------------------------------------
// angle_pid_controller_core
// PID regulator for a heading angle in signed Q16.16, with a wrapped error,
// a clamped integral, a derivative divided by the sample interval and a
// saturated output.
//
//   channel | handshake            | payload                         | dir
//   --------+----------------------+---------------------------------+-----
//   in      | in_valid, in_ready   | op, measured_angle, interval    | in
//   out     | out_valid, out_ready | drive, clamped                  | out
//   cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data             | in
//
// An update beat runs through the idle step that takes it, seven sequencing
// steps (five of them on the shared 32x32 multiplier), the divider (two
// quotient bits per cycle) and the saturation step. A zero interval skips
// the divider. A clear beat runs through the idle, error and saturation
// steps. Reset clears the configuration registers, the integral and the
// previous error. A new beat is taken once the previous one has been handed
// to the output register; a stalled output holds only the final step.
// ----------------------------------------------------------------------------
module angle_pid_controller_core
    import apc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic signed [31:0]   measured_angle,
    input  logic        [15:0]   interval,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   drive,
    output logic                 clamped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    apc_state_t state_reg, state_next;

    logic signed [31:0] setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic        [30:0] drive_limit_reg, integral_limit_reg;

    logic               op_reg, op_next;
    logic signed [31:0] meas_reg, meas_next;
    logic        [15:0] dt_reg, dt_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] num_reg, num_next;
    logic signed [31:0] esum_reg, esum_next;
    logic signed [31:0] prev_err_reg, prev_err_next;
    logic signed [31:0] drive_reg, drive_next;
    logic               clamped_reg, clamped_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [31:0] mul_a, mul_b;
    logic               div_start;
    logic               div_done;
    logic signed [63:0] div_quo;

    logic signed [32:0] diff, wrapped;
    logic signed [31:0] err_sat;
    logic signed [31:0] inc;
    logic signed [32:0] isum, ilim, ilim_neg;
    logic signed [31:0] esum_clamped;
    logic signed [63:0] dlim, dlim_neg;
    logic signed [31:0] lim32;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    apc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (num_reg),
        .denom    (dt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            setpoint_reg       <= '0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            drive_limit_reg    <= '0;
            integral_limit_reg <= '0;
            esum_reg           <= '0;
            prev_err_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            esum_reg      <= esum_next;
            prev_err_reg  <= prev_err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SETPOINT:       setpoint_reg       <= $signed(cfg_data);
                    CFG_GAIN_P:         gain_p_reg         <= $signed(cfg_data);
                    CFG_GAIN_I:         gain_i_reg         <= $signed(cfg_data);
                    CFG_GAIN_D:         gain_d_reg         <= $signed(cfg_data);
                    CFG_DRIVE_LIMIT:    drive_limit_reg    <= cfg_data[30:0];
                    CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[30:0];
                    default:            setpoint_reg       <= setpoint_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        meas_reg    <= meas_next;
        dt_reg      <= dt_next;
        err_reg     <= err_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:    state_next = (op_reg == OP_CLEAR) ? ST_SAT : ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_E;
            ST_MUL_E:  state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_DNUM_A;
            ST_DNUM_A: state_next = ST_DNUM_B;
            ST_DNUM_B: state_next = ST_ITERM;
            ST_ITERM:  state_next = (dt_reg != '0) ? ST_DIV : ST_SAT;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, divider start.
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            ST_MUL_E:
            begin
                mul_a = err_reg;
                mul_b = $signed({16'b0, dt_reg});
            end
            ST_INTEG:
            begin
                mul_a = gain_d_reg;
                mul_b = err_reg;
            end
            ST_DNUM_A:
            begin
                mul_a = gain_d_reg;
                mul_b = prev_err_reg;
            end
            ST_DNUM_B:
            begin
                mul_a = gain_i_reg;
                mul_b = esum_reg;
            end
            ST_ITERM: div_start = (dt_reg != '0);
            default:  in_ready = 1'b0;
        endcase
    end

    // Error wrap and saturation, integral clamp, output limit.
    always_comb
    begin
        diff = {setpoint_reg[31], setpoint_reg} - {meas_reg[31], meas_reg};
        if (diff > DEG180)
        begin
            wrapped = diff - DEG360;
        end
        else if (diff < NEG_DEG180)
        begin
            wrapped = diff + DEG360;
        end
        else
        begin
            wrapped = diff;
        end
        if (wrapped[32] != wrapped[31])
        begin
            err_sat = wrapped[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            err_sat = wrapped[31:0];
        end

        // The error times the interval fits 48 bits, so its floor shift fits 32.
        inc      = prod_reg[47:16];
        isum     = {esum_reg[31], esum_reg} + {inc[31], inc};
        ilim     = $signed({2'b0, integral_limit_reg});
        ilim_neg = -ilim;
        if (isum > ilim)
        begin
            esum_clamped = ilim[31:0];
        end
        else if (isum < ilim_neg)
        begin
            esum_clamped = ilim_neg[31:0];
        end
        else
        begin
            esum_clamped = isum[31:0];
        end

        dlim     = $signed({33'b0, drive_limit_reg});
        dlim_neg = -dlim;
        lim32    = $signed({1'b0, drive_limit_reg});
    end

    // Datapath.
    always_comb
    begin
        op_next        = op_reg;
        meas_next      = meas_reg;
        dt_next        = dt_reg;
        err_next       = err_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        esum_next      = esum_reg;
        prev_err_next  = prev_err_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        out_valid_next = out_valid_reg;
        prod_next      = mul_a * mul_b;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op;
                    meas_next = measured_angle;
                    dt_next   = interval;
                end
            end
            ST_ERR:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    esum_next     = '0;
                    prev_err_next = '0;
                    acc_next      = '0;
                end
                else
                begin
                    err_next = err_sat;
                end
            end
            ST_MUL_E:  acc_next = {{16{prod_reg[63]}}, prod_reg[63:16]};
            ST_INTEG:  esum_next = esum_clamped;
            ST_DNUM_A: num_next = prod_reg;
            ST_DNUM_B:
            begin
                num_next      = num_reg - prod_reg;
                prev_err_next = err_reg;
            end
            ST_ITERM:  acc_next = acc_reg + {{16{prod_reg[63]}}, prod_reg[63:16]};
            ST_DIV:
            begin
                if (div_done)
                begin
                    acc_next = acc_reg + div_quo;
                end
            end
            ST_SAT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (acc_reg > dlim)
                    begin
                        drive_next   = lim32;
                        clamped_next = 1'b1;
                    end
                    else if (acc_reg < dlim_neg)
                    begin
                        drive_next   = -lim32;
                        clamped_next = 1'b1;
                    end
                    else
                    begin
                        drive_next   = acc_reg[31:0];
                        clamped_next = 1'b0;
                    end
                end
            end
            default:   acc_next = acc_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    // The divider only finishes while the sequencer waits on it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the wait step");

    // A clamped result sits exactly at one of the two output limits.
    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && clamped_reg) |-> (drive_reg == lim32 || drive_reg == -lim32))
        else $error("clamped result not at the output limit");

    // A clear beat reaches the output step with a zero sum.
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT && op_reg == OP_CLEAR) |-> acc_reg == '0)
        else $error("clear beat with nonzero sum");

    // The previous error takes the current error once the derivative is formed.
    a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DNUM_B) |=> prev_err_reg == $past(err_reg))
        else $error("previous error not updated");

endmodule
